// ===== src/loam_pkg.sv =====
// ----------------------------------------------------------------------------
// loam_pkg: shared types and constants of the looped overlay audio mixer
// Register indexes, commands, field widths, state encodings and the
// arithmetic constants for the gap length and the mix division.
// ----------------------------------------------------------------------------
package loam_pkg;

  // overlay store
  localparam int OVERLAY_DEPTH = 65536;
  localparam int OVL_ADDR_W    = $clog2(OVERLAY_DEPTH);

  // field widths
  localparam int CMD_W     = 2;
  localparam int SAMPLE_W  = 8;
  localparam int LADDR_W   = 16;
  localparam int PCT_W     = 7;
  localparam int LEN_W     = 17;
  localparam int MUTE_W    = 16;
  localparam int RATE_W    = 18;
  localparam int BITS_W    = 6;
  localparam int GAP_W     = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;

  // gap length: mute_ms * rate * bytes / 1000
  localparam int BYTES_W      = BITS_W - 3;
  localparam int RB_W         = RATE_W + BYTES_W;
  localparam int GAP_PROD_W   = MUTE_W + RB_W;
  localparam int GAP_DIVISOR  = 1000;
  localparam int GAP_REM_W    = $clog2(GAP_DIVISOR);
  localparam int GAP_CNT_W    = $clog2(GAP_PROD_W);
  localparam logic [GAP_W-1:0] GAP_MAX = '1;

  // mix: weights in percent, division by 100 through a reciprocal
  localparam int PCT_FULL   = 100;
  localparam int ACC_W      = 16;
  localparam int MAG_W      = 14;
  localparam int DIV_SHIFT  = 19;
  localparam int DIV_RECIP  = (1 << DIV_SHIFT) / PCT_FULL + 1;
  localparam int DIV_PROD_W = MAG_W + DIV_SHIFT - 6;

  // register reset values
  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(16000);
  localparam logic [BITS_W-1:0] BITS_RST = BITS_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX_PERCENT = 3'd0,
    CFG_MIX_LENGTH  = 3'd1,
    CFG_MUTE_MS     = 3'd2,
    CFG_SAMPLE_RATE = 3'd3,
    CFG_SAMPLE_BITS = 3'd4
  } cfg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_MIX     = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // settings that feed the gap length unit
  typedef struct packed {
    logic [MUTE_W-1:0] mute_ms;
    logic [RATE_W-1:0] rate;
    logic [BITS_W-1:0] bits;
  } gap_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } mix_state_e;

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_MUL  = 3'b010,
    G_DIV  = 3'b100
  } gap_state_e;

endpackage

// ===== src/loam_if.sv =====
// ----------------------------------------------------------------------------
// loam channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface loam_req_if;
  import loam_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [LADDR_W-1:0]         load_address;

  modport source (output valid, command, sample_value, load_address, input ready);
  modport sink   (input valid, command, sample_value, load_address, output ready);
endinterface

interface loam_res_if;
  import loam_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic                       in_gap;

  modport source (output valid, mixed_sample, in_gap, input ready);
  modport sink   (input valid, mixed_sample, in_gap, output ready);
endinterface

interface loam_cfg_if;
  import loam_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/loam_gap_calc.sv =====
// ----------------------------------------------------------------------------
// loam_gap_calc: gap length unit
// Works out mute_ms * rate * (bits / 8) / 1000, saturated to the gap counter
// width, with a bit-serial shift-add multiply and a restoring divide.
// ----------------------------------------------------------------------------
module loam_gap_calc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  loam_pkg::gap_cfg_t        cfg_i,
  output logic                      busy_o,
  output logic [loam_pkg::GAP_W-1:0] gap_len_o
);
  import loam_pkg::*;

  gap_state_e              st_q, st_d;
  logic [GAP_CNT_W-1:0]    cnt_q, cnt_d;
  logic [RB_W-1:0]         rb_q, rb_d;
  logic [MUTE_W-1:0]       ms_q, ms_d;
  logic [GAP_PROD_W-1:0]   work_q, work_d;
  logic [GAP_REM_W-1:0]    rem_q, rem_d;
  logic [GAP_W-1:0]        gap_len_q, gap_len_d;
  logic [GAP_REM_W:0]      trial;
  logic                    trial_ge;

  assign trial    = {rem_q, work_q[GAP_PROD_W-1]};
  assign trial_ge = trial >= (GAP_REM_W+1)'(GAP_DIVISOR);

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    rb_d      = rb_q;
    ms_d      = ms_q;
    work_d    = work_q;
    rem_d     = rem_q;
    gap_len_d = gap_len_q;
    if (start_i) begin
      rb_d   = RB_W'(cfg_i.rate) * RB_W'(cfg_i.bits[BITS_W-1:3]);
      ms_d   = cfg_i.mute_ms;
      work_d = '0;
      cnt_d  = '0;
      st_d   = G_MUL;
    end else begin
      unique case (st_q)
        G_IDLE: ;
        G_MUL: begin
          // one multiplier bit a cycle, msb first
          work_d = {work_q[GAP_PROD_W-2:0], 1'b0}
                 + (ms_q[MUTE_W-1] ? GAP_PROD_W'(rb_q) : '0);
          ms_d   = {ms_q[MUTE_W-2:0], 1'b0};
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == GAP_CNT_W'(MUTE_W - 1)) begin
            cnt_d = '0;
            rem_d = '0;
            st_d  = G_DIV;
          end
        end
        G_DIV: begin
          // quotient bits shift in where dividend bits leave
          rem_d  = trial_ge ? GAP_REM_W'(trial - (GAP_REM_W+1)'(GAP_DIVISOR))
                            : trial[GAP_REM_W-1:0];
          work_d = {work_q[GAP_PROD_W-2:0], trial_ge};
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == GAP_CNT_W'(GAP_PROD_W - 1)) begin
            gap_len_d = (|work_d[GAP_PROD_W-1:GAP_W]) ? GAP_MAX : work_d[GAP_W-1:0];
            st_d      = G_IDLE;
          end
        end
        default: st_d = G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= G_IDLE;
      cnt_q     <= '0;
      gap_len_q <= '0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      gap_len_q <= gap_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rb_q   <= rb_d;
    ms_q   <= ms_d;
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign busy_o    = (st_q != G_IDLE);
  assign gap_len_o = gap_len_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("gap unit not busy after start");

  a_mul_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == G_MUL) |-> (cnt_q < GAP_CNT_W'(MUTE_W)))
    else $error("multiply step count out of range");

  a_div_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == G_DIV) |-> (cnt_q < GAP_CNT_W'(GAP_PROD_W)))
    else $error("divide step count out of range");

endmodule

// ===== src/looped_overlay_audio_mixer.sv =====
// ----------------------------------------------------------------------------
// looped_overlay_audio_mixer: audio byte mixer with a looping overlay sound
// Mixes signed audio bytes with a stored overlay that repeats after a gap.
// ----------------------------------------------------------------------------
// Usage
//   req_i carries one request: a mix (audio byte), a load (overlay byte into
//   the store at load_address) or a restart (play position and gap cleared).
//   res_o carries one result per mix request: mixed_sample and in_gap.
//   cfg_i writes the registers, indexed in the order percent, length, mute ms,
//   sample rate, sample bits; unknown indexes are taken and ignored.
// Sequence
//   a mix request is accepted together with the store read, then passes its
//   2-bit weight digits through the multiply-accumulate, then the divide by
//   100 and the hand-over to the output register; a zero loop length goes
//   straight to the hand-over. load, restart and unused commands give no
//   result. after each register write the gap length is worked out
//   bit-serially in 16 multiply steps and 37 divide steps, and req_i.ready
//   stays low meanwhile.
// Reset clears the play position, the gap counter and the registers to their
//   defaults; the overlay store keeps no reset value and must be loaded first.
// A stalled result holds in the output register; the next mix request waits
//   in its hand-over cycle until that register is free.
// ----------------------------------------------------------------------------
module looped_overlay_audio_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  loam_req_if.sink    req_i,
  loam_res_if.source  res_o,
  loam_cfg_if.sink    cfg_i
);
  import loam_pkg::*;

  // registers
  logic [PCT_W-1:0] mix_percent_q;
  logic [LEN_W-1:0] mix_length_q;
  gap_cfg_t         gap_cfg_q;
  logic             cfg_pend_q;
  logic             cfg_fire;

  // gap unit
  logic             gap_busy;
  logic [GAP_W-1:0] gap_len;

  // playback state
  mix_state_e        state_q, state_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [GAP_W-1:0]  gap_rem_q, gap_rem_d;

  // datapath
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic [SAMPLE_W-1:0]        ovl_rd_q;
  logic [7:0]                 wp_sr_q, wp_sr_d;
  logic [7:0]                 ws_sr_q, ws_sr_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       mute_q, mute_d;
  logic [SAMPLE_W-1:0]        res_q, res_d;

  // output register
  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_data_q;
  logic                       out_gap_q;
  logic                       out_load;

  logic                       req_fire;
  logic                       ovl_rd_en;
  logic                       ovl_wr_en;
  logic [PCT_W-1:0]           p_sat;
  logic                       wrap;
  logic [LEN_W-1:0]           pos_base;
  logic [GAP_W-1:0]           gap_base;
  logic signed [10:0]         s_ext, o_ext, dq_ext, dp_ext, term_s, term_o;
  logic [ACC_W-1:0]           mag16;
  logic [DIV_PROD_W-1:0]      prod;
  logic [SAMPLE_W-1:0]        quot;

  logic [SAMPLE_W-1:0] ovl_mem [OVERLAY_DEPTH];

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_percent_q     <= '0;
      mix_length_q      <= '0;
      gap_cfg_q.mute_ms <= '0;
      gap_cfg_q.rate    <= RATE_RST;
      gap_cfg_q.bits    <= BITS_RST;
      cfg_pend_q        <= 1'b0;
    end else begin
      cfg_pend_q <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_i.index)
          CFG_MIX_PERCENT: mix_percent_q     <= cfg_i.data[PCT_W-1:0];
          CFG_MIX_LENGTH:  mix_length_q      <= cfg_i.data[LEN_W-1:0];
          CFG_MUTE_MS:     gap_cfg_q.mute_ms <= cfg_i.data[MUTE_W-1:0];
          CFG_SAMPLE_RATE: gap_cfg_q.rate    <= cfg_i.data[RATE_W-1:0];
          CFG_SAMPLE_BITS: gap_cfg_q.bits    <= cfg_i.data[BITS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  loam_gap_calc u_gap_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_pend_q),
    .cfg_i     (gap_cfg_q),
    .busy_o    (gap_busy),
    .gap_len_o (gap_len)
  );

  // ---------------------------------------------------------------- request
  assign req_i.ready = (state_q == ST_IDLE) & ~gap_busy & ~cfg_pend_q & ~cfg_i.valid;
  assign req_fire    = req_i.valid & req_i.ready;

  assign p_sat = (mix_percent_q > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : mix_percent_q;

  // wrap check comes before the byte is taken
  assign wrap     = (pos_q >= mix_length_q);
  assign pos_base = wrap ? '0 : pos_q;
  assign gap_base = wrap ? gap_len : gap_rem_q;

  assign ovl_wr_en = req_fire && (req_i.command == CMD_LOAD);
  assign ovl_rd_en = req_fire && (req_i.command == CMD_MIX) && (mix_length_q != '0)
                     && (gap_base == '0);

  always_ff @(posedge clk_i) begin
    if (ovl_wr_en) begin
      ovl_mem[OVL_ADDR_W'(req_i.load_address)] <= req_i.sample_value;
    end
    if (ovl_rd_en) begin
      ovl_rd_q <= ovl_mem[OVL_ADDR_W'(pos_base)];
    end
  end

  // ---------------------------------------------------------------- mix datapath
  // one 2-bit digit of each weight per cycle, msb first
  assign s_ext  = 11'(sample_q);
  assign o_ext  = mute_q ? '0 : 11'($signed(ovl_rd_q));
  assign dq_ext = 11'(ws_sr_q[7:6]);
  assign dp_ext = 11'(wp_sr_q[7:6]);
  assign term_s = s_ext * dq_ext;
  assign term_o = o_ext * dp_ext;

  // magnitude times ceil(2^19/100), exact for the mix range
  assign mag16 = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign prod  = DIV_PROD_W'(mag16[MAG_W-1:0]) * DIV_PROD_W'(DIV_RECIP);
  assign quot  = prod[DIV_SHIFT +: SAMPLE_W];

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    gap_rem_d = gap_rem_q;
    sample_d  = sample_q;
    wp_sr_d   = wp_sr_q;
    ws_sr_d   = ws_sr_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    mute_d    = mute_q;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.command)
            CMD_MIX: begin
              sample_d = req_i.sample_value;
              if (mix_length_q == '0) begin
                // pass-through, state untouched
                res_d   = req_i.sample_value;
                mute_d  = 1'b0;
                state_d = ST_OUT;
              end else begin
                if (gap_base != '0) begin
                  gap_rem_d = gap_base - 1'b1;
                  pos_d     = pos_base;
                  mute_d    = 1'b1;
                end else begin
                  gap_rem_d = gap_base;
                  pos_d     = pos_base + 1'b1;
                  mute_d    = 1'b0;
                end
                wp_sr_d = {1'b0, p_sat};
                ws_sr_d = {1'b0, PCT_W'(PCT_FULL) - p_sat};
                acc_d   = '0;
                cnt_d   = '0;
                state_d = ST_MAC;
              end
            end
            CMD_RESTART: begin
              pos_d     = '0;
              gap_rem_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        acc_d   = (acc_q <<< 2) + ACC_W'(term_s) + ACC_W'(term_o);
        wp_sr_d = {wp_sr_q[5:0], 2'b00};
        ws_sr_d = {ws_sr_q[5:0], 2'b00};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        res_d   = acc_q[ACC_W-1] ? (~quot + 1'b1) : quot;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      gap_rem_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      gap_rem_q <= gap_rem_d;
      cnt_q     <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    wp_sr_q  <= wp_sr_d;
    ws_sr_q  <= ws_sr_d;
    acc_q    <= acc_d;
    mute_q   <= mute_d;
    res_q    <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
      out_gap_q  <= mute_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.mixed_sample = out_data_q;
  assign res_o.in_gap       = out_gap_q;

  // ---------------------------------------------------------------- checks
  a_busy_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gap_busy || cfg_pend_q) |-> !req_i.ready)
    else $error("request taken while gap length is being worked out");

  a_mix_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.command == CMD_MIX && mix_length_q != '0) |=> state_q == ST_MAC)
    else $error("mix request did not enter the multiply");

  a_mac_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && cnt_q == 2'd3) |=> state_q == ST_DIV)
    else $error("multiply did not end after four digits");

  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not handed to the output register");

endmodule

// ===== tb/sv/tb_looped_overlay_audio_mixer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_looped_overlay_audio_mixer: self-checking bench for the overlay mixer
// Drives mix, load, restart and unused requests through a queued driver, predicts
// every mixed byte with a cycle-free model of the loop and silent gap, and
// compares each result field by field across several register settings,
// random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_looped_overlay_audio_mixer;
  import loam_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd7;
  localparam int                   SETTLE_CYCLES = 16;
  localparam int                   HOLD_CYCLES   = 300;
  // later settings never play further than this from the loop start
  localparam int                   FILL_MAX      = 192;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LADDR_W-1:0]         addr;
  } audio_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed;
    logic                       in_gap;
  } mix_res_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic hold_go = 1'b0;
  logic rx_hold;

  loam_req_if req_if ();
  loam_res_if res_if ();
  loam_cfg_if cfg_if ();

  looped_overlay_audio_mixer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic signed [SAMPLE_W-1:0] ovl_mem [OVERLAY_DEPTH];
  logic [LEN_W-1:0]  play_pos;
  logic [GAP_W-1:0]  gap_left;
  logic [PCT_W-1:0]  pct_reg;
  logic [LEN_W-1:0]  len_reg;
  logic [MUTE_W-1:0] mute_reg;
  logic [RATE_W-1:0] rate_reg;
  logic [BITS_W-1:0] bits_reg;

  audio_req_t audio_req_q [$];
  mix_res_t   mixes_due_q [$];
  audio_req_t cur_req;
  mix_res_t   next_res;
  mix_res_t   due_res;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int filled_to     = 0;
  int err_cnt       = 0;
  int n_mixes       = 0;
  int n_gap_mixes   = 0;
  int n_loads       = 0;
  int n_restarts    = 0;
  int n_settings    = 0;

  function automatic bit predict_mix(input audio_req_t r, output mix_res_t res);
    int p;
    int ovl;
    int acc;
    longint unsigned g;
    res = '0;
    case (r.cmd)
      CMD_LOAD: begin
        ovl_mem[r.addr] = r.sample;
        return 1'b0;
      end
      CMD_RESTART: begin
        play_pos = '0;
        gap_left = '0;
        return 1'b0;
      end
      CMD_MIX: ;
      default: return 1'b0;
    endcase
    if (len_reg == 0) begin
      res.mixed = r.sample;
      return 1'b1;
    end
    p = (pct_reg > PCT_FULL) ? PCT_FULL : int'(pct_reg);
    // wrap is checked before the byte is taken
    if (play_pos >= len_reg) begin
      g = longint'(mute_reg) * rate_reg * (bits_reg / 8) / GAP_DIVISOR;
      play_pos = '0;
      gap_left = (g > GAP_MAX) ? GAP_MAX : g[GAP_W-1:0];
    end
    if (gap_left != 0) begin
      gap_left = gap_left - 1'b1;
      ovl = 0;
      res.in_gap = 1'b1;
    end else begin
      ovl = ovl_mem[play_pos[OVL_ADDR_W-1:0]];
      play_pos = play_pos + 1'b1;
    end
    acc = (int'(r.sample) * (PCT_FULL - p) + ovl * p) / PCT_FULL;
    res.mixed = acc[SAMPLE_W-1:0];
    return 1'b1;
  endfunction

  // driver: one request offered at a time, prediction on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_MIX;
      req_if.sample_value <= '0;
      req_if.load_address <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        case (cur_req.cmd)
          CMD_MIX:     n_mixes++;
          CMD_LOAD:    n_loads++;
          CMD_RESTART: n_restarts++;
          default: ;
        endcase
        if (predict_mix(cur_req, next_res)) mixes_due_q.push_back(next_res);
      end
      if (!req_if.valid || req_if.ready) begin
        if (audio_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = audio_req_q.pop_front();
          req_if.command      <= cur_req.cmd;
          req_if.sample_value <= cur_req.sample;
          req_if.load_address <= cur_req.addr;
          req_if.valid        <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (mixes_due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got mixed_sample %0d in_gap %0b",
                   $time, $signed(res_if.mixed_sample), res_if.in_gap);
        end else begin
          due_res = mixes_due_q.pop_front();
          if (res_if.mixed_sample !== due_res.mixed) begin
            err_cnt++;
            $display("%0t: mixed_sample expected %0d got %0d", $time,
                     $signed(due_res.mixed), $signed(res_if.mixed_sample));
          end
          if (res_if.in_gap !== due_res.in_gap) begin
            err_cnt++;
            $display("%0t: in_gap expected %0b got %0b", $time, due_res.in_gap,
                     res_if.in_gap);
          end
          if (due_res.in_gap) n_gap_mixes++;
        end
      end
      res_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    rx_hold = 1'b0;
    @(posedge hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #3000000;
    $display("[looped_overlay_audio_mixer] ERROR");
    $finish;
  end

  task automatic queue_req(input logic [CMD_W-1:0] c, input logic [SAMPLE_W-1:0] s,
                           input logic [LADDR_W-1:0] a);
    audio_req_t r;
    r.cmd    = c;
    r.sample = s;
    r.addr   = a;
    audio_req_q.push_back(r);
  endtask

  task automatic queue_random(input int n);
    int k;
    logic [CMD_W-1:0] c;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 80)      c = CMD_MIX;
      else if (k < 90) c = CMD_LOAD;
      else if (k < 96) c = CMD_RESTART;
      else             c = CMD_SPARE;
      queue_req(c, SAMPLE_W'($urandom), LADDR_W'($urandom));
    end
  endtask

  // wait until every request is taken and every result is back
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (audio_req_q.size() != 0 || req_if.valid || mixes_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_MIX_PERCENT: pct_reg  = val[PCT_W-1:0];
      CFG_MIX_LENGTH:  len_reg  = val[LEN_W-1:0];
      CFG_MUTE_MS:     mute_reg = val[MUTE_W-1:0];
      CFG_SAMPLE_RATE: rate_reg = val[RATE_W-1:0];
      CFG_SAMPLE_BITS: bits_reg = val[BITS_W-1:0];
      default: ;
    endcase
  endtask

  // new settings, then load every store entry the loop can reach
  task automatic configure(input int pct, input int len, input int mute, input int rate,
                           input int bits);
    int want;
    wait_quiet();
    write_reg(CFG_MIX_PERCENT, CFG_DAT_W'(pct));
    write_reg(CFG_MIX_LENGTH, CFG_DAT_W'(len));
    write_reg(CFG_MUTE_MS, CFG_DAT_W'(mute));
    write_reg(CFG_SAMPLE_RATE, CFG_DAT_W'(rate));
    write_reg(CFG_SAMPLE_BITS, CFG_DAT_W'(bits));
    n_settings++;
    want = (len < OVERLAY_DEPTH) ? len : OVERLAY_DEPTH;
    if (want > FILL_MAX) want = FILL_MAX;
    while (filled_to < want) begin
      queue_req(CMD_LOAD, SAMPLE_W'($urandom), LADDR_W'(filled_to));
      filled_to++;
    end
  endtask

  initial begin
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_MIX_PERCENT;
    cfg_if.data         <= '0;
    play_pos = '0;
    gap_left = '0;
    pct_reg  = '0;
    len_reg  = '0;
    mute_reg = '0;
    rate_reg = RATE_RST;
    bits_reg = BITS_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 83;

    // zero length: straight pass-through, plus the ignored command
    queue_req(CMD_MIX, 8'sh80, '0);
    queue_req(CMD_MIX, 8'sh7f, '0);
    queue_req(CMD_MIX, 8'sh00, 16'hffff);
    queue_req(CMD_LOAD, 8'shff, 16'hffff);
    queue_req(CMD_SPARE, 8'sh55, 16'h1234);
    queue_req(CMD_RESTART, 8'sh00, '0);
    queue_req(CMD_MIX, 8'shff, '0);

    // weight above full scale, wrap into a three byte gap, restart
    wait_quiet();
    write_reg(CFG_SPARE, '1);
    configure(127, 3, 1, 3000, 8);
    queue_req(CMD_LOAD, 8'sh80, 16'd0);
    queue_req(CMD_LOAD, 8'sh7f, 16'd1);
    queue_req(CMD_LOAD, 8'shff, 16'd2);
    queue_req(CMD_MIX, 8'sh7f, '0);
    queue_req(CMD_MIX, 8'sh80, '0);
    repeat (6) queue_req(CMD_MIX, SAMPLE_W'($urandom), '0);
    queue_req(CMD_RESTART, 8'sh00, '0);
    queue_req(CMD_MIX, 8'sh80, '0);

    configure(37, 17, 2, 8000, 8);
    queue_random(40);
    wait_quiet();
    queue_random(40);
    configure(0, 1, 0, 16000, 16);
    queue_random(70);
    configure(100, 64, 1, 1, 63);
    queue_random(70);

    send_idle_pct = 83;
    recv_idle_pct = 28;
    configure($urandom_range(1, 99), 9, 5, 1000, 32);
    queue_random(80);
    // gap length saturates, so only restarts bring the overlay back
    configure(127, 5, 65535, 262143, 63);
    queue_random(70);
    configure($urandom_range(1, 99), 6, 65535, 0, 7);
    queue_random(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(50, 33, 1, 16000, 16);
    hold_go = 1'b1;
    queue_random(100);
    configure($urandom_range(0, 100), 65536, 2, 44100, 24);
    queue_random(100);
    configure($urandom_range(0, 100), 131071, 0, 192000, 8);
    queue_random(50);
    configure(100, 2, 0, 16000, 16);
    queue_random(40);

    wait_quiet();
    $display("covered %0d mixes (%0d in the silent gap), %0d loads, %0d restarts",
             n_mixes, n_gap_mixes, n_loads, n_restarts);
    $display("over %0d register settings with a %0d cycle receiver hold-off",
             n_settings, HOLD_CYCLES);
    if (err_cnt == 0 && mixes_due_q.size() == 0) begin
      $display("[looped_overlay_audio_mixer] OK");
    end else begin
      $display("[looped_overlay_audio_mixer] ERROR");
    end
    $finish;
  end

endmodule
